>>> design/mfd_pkg.sv
// Package with shared constants and types for the motor feedback decoder.
package mfd_pkg;
  localparam int NumMotorsDef = 4;
  localparam int IdW = 11;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 44;
  localparam logic signed [33:0] TurnJump = 34'sd393216;
  localparam logic [3:0] FaultFirst = 4'h8;
  localparam logic [3:0] FaultLast = 4'hE;
  localparam int PosBits = 16;
  localparam int VtBits = 12;

  localparam logic [CfgIdxW-1:0] RegIds = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCount = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPosMin = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPosMax = 3'd3;
  localparam logic [CfgIdxW-1:0] RegVelMin = 3'd4;
  localparam logic [CfgIdxW-1:0] RegVelMax = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTqMin = 3'd6;
  localparam logic [CfgIdxW-1:0] RegTqMax = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_MUL, S_DIV, S_TURN, S_OUT
  } state_t;
endpackage

>>> design/motor_feedback_decoder_multiturn_top.sv
// Top level of the motor feedback decoder with multi-turn tracking.
//
// Usage: a received CAN feedback frame enters on the s_axis channel, with
// tdata holding the 11-bit identifier in the low bits and the 64 payload
// bits above it. The identifier is compared against the configured table
// of motor ids; a frame that matches no entry in use is dropped with no
// result. A matching frame yields one result request on m_axis with the
// scaled position, velocity and torque, the temperature bytes, the turn
// count, the multi-turn position and the fault code.
// Each frame is processed one at a time. The three scalings run one after
// another through a single bit-serial shift-add multiplier (one product
// bit per cycle) and a restoring divider (one quotient bit per cycle).
// A matching frame first tests the table entries in order up to the hit,
// then runs the multiply and the divide for the position, then for the
// velocity and the torque, and finally updates the turn count; a dropped
// frame frees the input once every table entry in use has been tested.
// The result sits in an output register; while the receiver stalls, the
// block holds that result and takes no new frame.
// Reset (synchronous, rst high) clears the registers to their reset
// values, the turn counts and the remembered positions of every motor.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
module motor_feedback_decoder_multiturn_top #(
  parameter int NUM_MOTORS = mfd_pkg::NumMotorsDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // bits: frame_id[10:0], payload[74:11], zero fill [79:75]
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // bits: motor_index[1:0], position[33:2], velocity[65:34], torque[97:66],
  // mos_temp[105:98], rotor_temp[113:106], turn_count[129:114],
  // multi_turn_position[177:130], fault[180:178], zero fill [183:181]
  output logic [183:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [mfd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mfd_pkg::CfgDataW-1:0] cfg_data
);
  localparam int IdxW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  // Configuration registers.
  logic [43:0] motor_ids;
  logic [2:0]  motor_count;
  logic signed [31:0] lim_min [3];
  logic signed [31:0] lim_max [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_ids <= '0;
      motor_count <= '0;
      lim_min[0] <= -32'sd819200;  lim_max[0] <= 32'sd819200;
      lim_min[1] <= -32'sd1966080; lim_max[1] <= 32'sd1966080;
      lim_min[2] <= -32'sd655360;  lim_max[2] <= 32'sd655360;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfd_pkg::RegIds:    motor_ids <= cfg_data;
        mfd_pkg::RegCount:  motor_count <= cfg_data[2:0];
        mfd_pkg::RegPosMin: lim_min[0] <= cfg_data[31:0];
        mfd_pkg::RegPosMax: lim_max[0] <= cfg_data[31:0];
        mfd_pkg::RegVelMin: lim_min[1] <= cfg_data[31:0];
        mfd_pkg::RegVelMax: lim_max[1] <= cfg_data[31:0];
        mfd_pkg::RegTqMin:  lim_min[2] <= cfg_data[31:0];
        mfd_pkg::RegTqMax:  lim_max[2] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Per-motor state.
  logic signed [31:0] prev_pos [NUM_MOTORS];
  logic signed [15:0] turns [NUM_MOTORS];

  mfd_pkg::state_t state, state_next;
  logic [mfd_pkg::IdW-1:0] frame_id;
  logic [63:0] payload;
  logic [1:0]  ch;         // which field is being scaled
  logic [2:0]  scan;       // table entry under test
  logic [IdxW-1:0] hit;
  logic [5:0]  cnt;
  logic [16:0] mcand;      // multiplier bits, shifted out LSB first
  logic [32:0] span_mag;
  logic        neg;
  logic [48:0] acc;        // product magnitude
  logic [16:0] rem;
  logic [48:0] quo;
  logic signed [31:0] res [3];
  logic signed [15:0] t_out;
  logic signed [47:0] multi;
  logic [2:0]  fault;

  logic [2:0] used;
  assign used = (motor_count > 3'(NUM_MOTORS)) ? 3'(NUM_MOTORS) : motor_count;

  logic [mfd_pkg::IdW-1:0] cur_id;
  assign cur_id = motor_ids[11*scan[1:0] +: 11];

  logic [15:0] code;
  always_comb begin
    case (ch)
      2'd0: code = payload[55:40];
      2'd1: code = {4'd0, payload[39:28]};
      default: code = {4'd0, payload[27:16]};
    endcase
  end
  logic [16:0] divisor;
  assign divisor = (ch == 2'd0) ? 17'd65535 : 17'd4095;
  logic [5:0] mul_len;
  assign mul_len = (ch == 2'd0) ? 6'd16 : 6'd12;

  logic signed [32:0] span;
  assign span = 33'(lim_max[ch]) - 33'(lim_min[ch]);

  // One restoring division step.
  logic [17:0] trial;
  assign trial = {rem, quo[48]} - {1'b0, divisor};
  logic signed [33:0] sum;
  assign sum = 34'(lim_min[ch]) + (neg ? -34'(signed'({1'b0, quo[32:0]}))
                                        : 34'(signed'({1'b0, quo[32:0]})));
  logic signed [31:0] clamped;
  assign clamped = (sum > 34'sd2147483647) ? 32'h7fffffff :
                   (sum < -34'sd2147483648) ? 32'h80000000 : sum[31:0];

  logic signed [33:0] diff;
  assign diff = 34'(prev_pos[hit]) - 34'(res[0]);

  // Turn count after this frame, saturating at the 16-bit range.
  logic signed [15:0] turn_next;
  always_comb begin
    turn_next = turns[hit];
    if (diff > mfd_pkg::TurnJump && turns[hit] != 16'sh7fff)
      turn_next = turns[hit] + 16'sd1;
    else if (diff < -mfd_pkg::TurnJump && turns[hit] != 16'sh8000)
      turn_next = turns[hit] - 16'sd1;
  end

  logic fire_in;
  assign fire_in = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == mfd_pkg::S_IDLE);
  assign m_axis_tvalid = (state == mfd_pkg::S_OUT);

  always_comb begin
    state_next = state;
    unique case (state)
      mfd_pkg::S_IDLE: if (fire_in) state_next = mfd_pkg::S_MATCH;
      mfd_pkg::S_MATCH:
        if (scan >= used) state_next = mfd_pkg::S_IDLE;
        else if (cur_id == frame_id) state_next = mfd_pkg::S_MUL;
      mfd_pkg::S_MUL: if (cnt == mul_len) state_next = mfd_pkg::S_DIV;
      mfd_pkg::S_DIV: if (cnt == 6'd49) state_next =
          (ch == 2'd2) ? mfd_pkg::S_TURN : mfd_pkg::S_MUL;
      mfd_pkg::S_TURN: state_next = mfd_pkg::S_OUT;
      mfd_pkg::S_OUT: if (m_axis_tready) state_next = mfd_pkg::S_IDLE;
      default: state_next = mfd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mfd_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
        prev_pos[k] <= '0;
        turns[k] <= '0;
      end
      cnt <= '0;
      ch <= '0;
      scan <= '0;
    end else begin
      unique case (state)
        mfd_pkg::S_IDLE: if (fire_in) begin
          frame_id <= s_axis_tdata[10:0];
          payload <= s_axis_tdata[74:11];
          scan <= '0;
          ch <= '0;
          cnt <= '0;
          acc <= '0;
        end
        mfd_pkg::S_MATCH: begin
          if (scan < used && cur_id == frame_id) begin
            hit <= IdxW'(scan);
            mcand <= {1'b0, code};
            span_mag <= span[32] ? 33'(-span) : 33'(span);
            neg <= span[32] && (code != 16'd0);
            acc <= '0;
            cnt <= '0;
          end
          scan <= scan + 3'd1;
        end
        mfd_pkg::S_MUL: begin
          if (cnt == mul_len) begin
            rem <= '0;
            quo <= acc + 49'(divisor[16:1]);  // dividend with rounding bias d/2
            acc <= '0;
            cnt <= '0;
          end else begin
            if (mcand[0]) acc <= acc + (49'(span_mag) << cnt);
            mcand <= mcand >> 1;
            cnt <= cnt + 6'd1;
          end
        end
        mfd_pkg::S_DIV: begin
          if (cnt == 6'd49) begin
            res[ch] <= clamped;
            ch <= ch + 2'd1;
            cnt <= '0;
            acc <= '0;
            mcand <= {1'b0, (ch == 2'd0) ? {4'd0, payload[39:28]}
                                         : {4'd0, payload[27:16]}};
            span_mag <= (34'(lim_max[ch+2'd1]) - 34'(lim_min[ch+2'd1])) < 0
                ? 33'(34'(lim_min[ch+2'd1]) - 34'(lim_max[ch+2'd1]))
                : 33'(34'(lim_max[ch+2'd1]) - 34'(lim_min[ch+2'd1]));
            neg <= ((34'(lim_max[ch+2'd1]) - 34'(lim_min[ch+2'd1])) < 0) &&
                   (((ch == 2'd0) ? payload[39:28] : payload[27:16]) != 12'd0);
          end else begin
            if (!trial[17]) begin
              rem <= trial[16:0];
              quo <= {quo[47:0], 1'b1};
            end else begin
              rem <= {rem[15:0], quo[48]};
              quo <= {quo[47:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
          end
        end
        mfd_pkg::S_TURN: begin
          t_out <= turn_next;
          turns[hit] <= turn_next;
          prev_pos[hit] <= res[0];
        end
        default: ;
      endcase
    end
  end

  // The divider streams the 49 dividend bits MSB first while the quotient
  // bits shift into quo from the bottom, so quo holds the dividend during
  // division and the quotient after.
  always_comb begin
    multi = 48'(t_out) * 48'sd1638400 + 48'(res[0]);
  end

  always_comb begin
    fault = (payload[63:60] >= mfd_pkg::FaultFirst &&
             payload[63:60] <= mfd_pkg::FaultLast)
            ? 3'(payload[63:60] - mfd_pkg::FaultFirst + 4'd1) : 3'd0;
  end

  assign m_axis_tdata = {3'd0, fault, multi, t_out, payload[7:0], payload[15:8],
                         res[2], res[1], res[0], 2'(hit)};
endmodule

>>> design/mfd_checker.sv
// Port-level checker for the motor feedback decoder, bound to the top level.
module mfd_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [183:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input open while result pending");
  a_take: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result too early");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[183:181] == 3'd0)
    else $error("fill bits set");
endmodule

bind motor_feedback_decoder_multiturn_top mfd_checker u_mfd_checker (.*);

>>> sim/motor_feedback_decoder_multiturn_checker.sv
// Checker that predicts and compares the decoded feedback reports of the decoder.
`timescale 1ns / 100ps

module motor_feedback_decoder_multiturn_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [183:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [mfd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mfd_pkg::CfgDataW-1:0] cfg_data,
  output int           errors,
  output int           outstanding,
  output int           reports_seen
);
  typedef struct packed {
    logic [1:0]         motor_index;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] torque;
    logic [7:0]         mos_temp;
    logic [7:0]         rotor_temp;
    logic signed [15:0] turn_count;
    logic signed [47:0] multi_turn_position;
    logic [2:0]         fault;
  } report_t;

  report_t report_q[$];

  logic [43:0]        id_table;
  logic [2:0]         ids_in_use;
  logic signed [31:0] lim_lo[3];
  logic signed [31:0] lim_hi[3];
  logic signed [31:0] last_position[4];
  logic signed [15:0] turns_held[4];

  // Linear scaling of a code into Q16.16 with round to nearest.
  function automatic logic signed [31:0] scale_code(input longint code,
      input logic signed [31:0] lo, input logic signed [31:0] hi, input int bits);
    longint span, divisor, prod, mag, quot, res;
    span = longint'(hi) - longint'(lo);
    divisor = (longint'(1) << bits) - 1;
    prod = code * span;
    mag = (prod < 0) ? -prod : prod;
    quot = (mag + divisor / 2) / divisor;
    res = longint'(lo) + ((prod < 0) ? -quot : quot);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  // Decodes one frame; returns 0 when the identifier matches no entry in use.
  function automatic bit decode_feedback(input logic [10:0] frame_id,
      input logic [63:0] payload, output report_t rep);
    int used, hit;
    longint diff, turns, multi;
    logic [3:0] nib;
    used = (ids_in_use > mfd_pkg::NumMotorsDef) ? mfd_pkg::NumMotorsDef : ids_in_use;
    hit = -1;
    for (int k = used - 1; k >= 0; k--)
      if (id_table[11*k +: 11] == frame_id) hit = k;
    if (hit < 0) return 0;
    rep.motor_index = hit[1:0];
    rep.position = scale_code(payload[55:40], lim_lo[0], lim_hi[0], mfd_pkg::PosBits);
    rep.velocity = scale_code(payload[39:28], lim_lo[1], lim_hi[1], mfd_pkg::VtBits);
    rep.torque = scale_code(payload[27:16], lim_lo[2], lim_hi[2], mfd_pkg::VtBits);
    rep.mos_temp = payload[15:8];
    rep.rotor_temp = payload[7:0];
    diff = longint'(last_position[hit]) - longint'(rep.position);
    turns = turns_held[hit];
    if (diff > 393216 && turns < 32767) turns++;
    if (diff < -393216 && turns > -32768) turns--;
    turns_held[hit] = turns[15:0];
    last_position[hit] = rep.position;
    multi = turns * 25 * 65536 + longint'(rep.position);
    rep.turn_count = turns[15:0];
    rep.multi_turn_position = multi[47:0];
    nib = payload[63:60];
    rep.fault = (nib >= mfd_pkg::FaultFirst && nib <= mfd_pkg::FaultLast)
                ? 3'(nib - mfd_pkg::FaultFirst + 1) : 3'd0;
    return 1;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    report_t rep, want;
    if (rst) begin
      id_table = '0;
      ids_in_use = '0;
      lim_lo[0] = -819200;  lim_hi[0] = 819200;
      lim_lo[1] = -1966080; lim_hi[1] = 1966080;
      lim_lo[2] = -655360;  lim_hi[2] = 655360;
      for (int k = 0; k < 4; k++) begin
        last_position[k] = '0;
        turns_held[k] = '0;
      end
      report_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mfd_pkg::RegIds:    id_table = cfg_data;
          mfd_pkg::RegCount:  ids_in_use = cfg_data[2:0];
          mfd_pkg::RegPosMin: lim_lo[0] = cfg_data[31:0];
          mfd_pkg::RegPosMax: lim_hi[0] = cfg_data[31:0];
          mfd_pkg::RegVelMin: lim_lo[1] = cfg_data[31:0];
          mfd_pkg::RegVelMax: lim_hi[1] = cfg_data[31:0];
          mfd_pkg::RegTqMin:  lim_lo[2] = cfg_data[31:0];
          mfd_pkg::RegTqMax:  lim_hi[2] = cfg_data[31:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        if (decode_feedback(s_axis_tdata[10:0], s_axis_tdata[74:11], rep))
          report_q.push_back(rep);
      if (m_axis_tvalid && m_axis_tready) begin
        reports_seen++;
        if (report_q.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = report_q.pop_front();
          check_field("motor_index", want.motor_index, m_axis_tdata[1:0]);
          check_field("position", want.position, $signed(m_axis_tdata[33:2]));
          check_field("velocity", want.velocity, $signed(m_axis_tdata[65:34]));
          check_field("torque", want.torque, $signed(m_axis_tdata[97:66]));
          check_field("mos_temp", want.mos_temp, m_axis_tdata[105:98]);
          check_field("rotor_temp", want.rotor_temp, m_axis_tdata[113:106]);
          check_field("turn_count", want.turn_count, $signed(m_axis_tdata[129:114]));
          check_field("multi_turn_position", want.multi_turn_position,
                      $signed(m_axis_tdata[177:130]));
          check_field("fault", want.fault, m_axis_tdata[180:178]);
        end
      end
    end
    outstanding = report_q.size();
  end
endmodule

>>> sim/motor_feedback_decoder_multiturn_top_test.sv
// Top of the testbench for the multi-turn motor feedback decoder.
`timescale 1ns / 100ps

module motor_feedback_decoder_multiturn_top_test;
  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // bits: frame_id[10:0], payload[74:11], zero fill [79:75]
  logic [79:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // bits: motor_index[1:0], position[33:2], velocity[65:34], torque[97:66],
  // mos_temp[105:98], rotor_temp[113:106], turn_count[129:114],
  // multi_turn_position[177:130], fault[180:178], zero fill [183:181]
  logic [183:0] m_axis_tdata;
  logic         cfg_we;
  logic [mfd_pkg::CfgIdxW-1:0]  cfg_index;
  logic [mfd_pkg::CfgDataW-1:0] cfg_data;

  int errors, outstanding, reports_seen;
  int frames_sent;
  int phases_run;
  logic [10:0] id_list[4];
  logic [15:0] walk_code[4];

  motor_feedback_decoder_multiturn_top dut (.*);

  motor_feedback_decoder_multiturn_checker checker_i (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we, .cfg_index, .cfg_data,
    .errors, .outstanding, .reports_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every input starts at a known value; reset starts asserted.
  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  // The receiver stalls at random. Once, after a couple of hundred reports,
  // it holds off long enough that the block keeps a result waiting and
  // stops taking frames while the sender is still offering them.
  initial begin
    int gap;
    bit held;
    bit calm;
    held = 0;
    calm = 0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) calm = !calm;
      gap = calm ? 0 : pick_gap();
      if (!held && reports_seen >= 200) begin
        held = 1;
        gap = 1500;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // Sends one frame request; valid stays high between back-to-back frames.
  task automatic send_frame(input logic [10:0] frame_id, input logic [63:0] payload,
                            input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, payload, frame_id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    frames_sent++;
  endtask

  // Lowers valid, waits for every expected report, then lets a dropped
  // frame still in flight finish before anything else happens.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Writes all eight registers on consecutive edges; the block is idle here.
  task automatic load_config(input logic [43:0] ids, input logic [2:0] count,
                             input logic [31:0] lims[6]);
    logic [mfd_pkg::CfgDataW-1:0] vals[8];
    vals[mfd_pkg::RegIds] = ids;
    vals[mfd_pkg::RegCount] = count;
    vals[mfd_pkg::RegPosMin] = lims[0]; vals[mfd_pkg::RegPosMax] = lims[1];
    vals[mfd_pkg::RegVelMin] = lims[2]; vals[mfd_pkg::RegVelMax] = lims[3];
    vals[mfd_pkg::RegTqMin] = lims[4];  vals[mfd_pkg::RegTqMax] = lims[5];
    for (int k = 0; k < 8; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= k[mfd_pkg::CfgIdxW-1:0];
      cfg_data <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    for (int k = 0; k < 4; k++) id_list[k] = ids[11*k +: 11];
    phases_run++;
  endtask

  // A random frame: most carry a table id and a position that walks by
  // steps around the turn threshold, so turn counting is exercised hard.
  task automatic send_random_frame(input int gap);
    logic [10:0] fid;
    logic [63:0] pl;
    int slot;
    slot = $urandom_range(0, 3);
    fid = ($urandom_range(0, 99) < 85) ? id_list[slot] : 11'($urandom_range(0, 2047));
    pl = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      walk_code[slot] = walk_code[slot] + 16'($signed($urandom_range(0, 60000)) - 30000);
      pl[55:40] = walk_code[slot];
    end
    send_frame(fid, pl, gap);
  endtask

  initial begin
    logic [31:0] lims[6];
    logic [43:0] ids;
    logic [63:0] pl;
    int n_items;
    bit calm;
    frames_sent = 0;
    phases_run = 0;
    calm = 0;
    for (int k = 0; k < 4; k++) walk_code[k] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at default limits: all four entries including the id
    // extremes, an unknown id, code extremes, every fault nibble, both
    // temperature extremes, and position jumps both ways.
    lims = '{-32'sd819200, 32'sd819200, -32'sd1966080, 32'sd1966080,
             -32'sd655360, 32'sd655360};
    load_config({11'h455, 11'h123, 11'h000, 11'h7FF}, 3'd4, lims);
    for (int k = 0; k < 22; k++) begin
      pl = '0;
      pl[63:60] = 4'(k);
      pl[55:40] = k[0] ? 16'hFFFF : 16'h0000;
      pl[39:28] = k[1] ? 12'hFFF : 12'h000;
      pl[27:16] = k[2] ? 12'h000 : 12'hFFF;
      pl[15:8] = k[0] ? 8'hFF : 8'h00;
      pl[7:0] = k[0] ? 8'h00 : 8'hFF;
      pl[59:56] = 4'($urandom);
      send_frame((k % 5 == 4) ? 11'h3AB : id_list[(k / 2) % 4], pl, k % 3);
    end
    drain();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      ids = 44'({$urandom, $urandom});
      n_items = 320;
      case (ph)
        0: begin
          // Widest span, and a count above the table size.
          lims = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF};
          load_config(ids, 3'd7, lims);
        end
        1: begin
          // Inverted limits at the extremes: the scale runs downward.
          lims = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000};
          load_config(ids, 3'd2, lims);
        end
        2: begin
          lims = '{-32'sd819200, 32'sd819200, -32'sd1966080, 32'sd1966080,
                   -32'sd655360, 32'sd655360};
          load_config(ids, 3'd4, lims);
        end
        3: begin
          // No entry in use, so every frame is dropped.
          n_items = 40;
          for (int k = 0; k < 6; k++) lims[k] = $urandom;
          load_config(ids, 3'd0, lims);
        end
        4: begin
          // Duplicate ids: the lowest entry must win.
          ids[21:11] = ids[10:0];
          ids[43:33] = ids[32:22];
          for (int k = 0; k < 6; k++) lims[k] = $urandom;
          load_config(ids, 3'd4, lims);
        end
        default: begin
          lims = '{-32'sd300000, 32'sd500000, 32'sd10, -32'sd10, 32'sd0, 32'sd4095};
          load_config(ids, 3'd1, lims);
        end
      endcase
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 39) == 0) calm = !calm;
        send_random_frame(calm ? 0 : pick_gap());
      end
      // The sender pauses here until every expected report has come.
      drain();
    end

    $display("Sent %0d frames over %0d register settings; %0d reports checked.",
             frames_sent, phases_run, reports_seen);
    $display("Settings covered full, inverted, default, empty, duplicate and narrow ranges.");
    if (errors == 0) begin
      $display("motor_feedback_decoder_multiturn_top_test passed");
    end else begin
      $display("motor_feedback_decoder_multiturn_top_test failed");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #30_000_000;
    $display("Timeout with %0d reports still expected.", outstanding);
    $display("motor_feedback_decoder_multiturn_top_test failed");
    $finish;
  end
endmodule
